// ----- hw/rtl/q16_pkg.sv -----
// Shared types and constants of the Q16.16 fixed-point arithmetic unit.
package q16_pkg;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_FLOOR = 3'd4,
      ACT_ABS = 3'd5
   } action_type;

   localparam int WORD_BITS = 32;
   localparam logic signed [WORD_BITS-1:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_BITS-1:0] NAN_CODE = 32'sh80000000;

endpackage

// ----- hw/rtl/q16_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for the Q16.16 unit.
module q16_div import q16_pkg::*; #(
   parameter int NUM_BITS = 48,
   parameter int DEN_BITS = 32,
   parameter int TAG_BITS = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output logic [NUM_BITS-1:0] out_quot,
   output logic [TAG_BITS-1:0] out_tag
);

   localparam int REM_BITS = DEN_BITS + 1;

   logic                valid_ff [NUM_BITS+1];
   logic [NUM_BITS-1:0] num_ff   [NUM_BITS+1];
   logic [REM_BITS-1:0] rem_ff   [NUM_BITS+1];
   logic [DEN_BITS-1:0] den_ff   [NUM_BITS+1];
   logic [TAG_BITS-1:0] tag_ff   [NUM_BITS+1];

   always_comb begin
      valid_ff[0] = in_valid;
      num_ff[0] = in_num;
      rem_ff[0] = '0;
      den_ff[0] = in_den;
      tag_ff[0] = in_tag;
   end

   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      logic [REM_BITS-1:0] trial_in;
      logic [REM_BITS:0]   diff_in;
      always_comb begin
         trial_in = {rem_ff[s][REM_BITS-2:0], num_ff[s][NUM_BITS-1]};
         diff_in = {1'b0, trial_in} - {2'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            num_ff[s+1] <= {num_ff[s][NUM_BITS-2:0], ~diff_in[REM_BITS]};
            rem_ff[s+1] <= diff_in[REM_BITS] ? trial_in : diff_in[REM_BITS-1:0];
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_BITS];
   assign out_quot = num_ff[NUM_BITS];
   assign out_tag = tag_ff[NUM_BITS];

endmodule

// ----- hw/rtl/q16_16_fixed_point_alu_top.sv -----
// Top level of the pipelined Q16.16 fixed-point arithmetic unit.
// Every action uses the same pipeline, so words leave in order.
// Its depth is set by the divider, one quotient bit a stage.
// Throughput: one word per cycle unless rsp stalls.
// A stall on rsp freezes the whole pipeline; req_ready is high whenever it advances.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
module q16_16_fixed_point_alu_top import q16_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_action,
   input  logic signed [WORD_BITS-1:0] req_operand_a,
   input  logic signed [WORD_BITS-1:0] req_operand_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_result,
   output logic                        rsp_overflow,
   output logic                        rsp_divide_by_zero
);

   localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
   localparam int WIDE = 2 * WORD_BITS + 1;
   // Tag carried beside the divider: other-action result (pre-saturation),
   // action, dividend sign, divisor sign, zero divisor flag.
   localparam int TAG_BITS = WIDE + 3 + 3;

   // The whole pipeline moves when the output register is empty or being taken.
   logic advance;
   assign advance = ~rsp_valid | rsp_ready;
   assign req_ready = advance;

   // Stage 1: register the request.
   logic                        s1_valid_ff;
   logic [2:0]                  s1_action_ff;
   logic signed [WORD_BITS-1:0] s1_a_ff, s1_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_action_ff <= req_action;
         s1_a_ff <= req_operand_a;
         s1_b_ff <= req_operand_b;
      end
   end

   // Stage 2: multiply and the simple actions; divider magnitudes.
   logic                        s2_valid_ff;
   logic [2:0]                  s2_action_ff;
   logic signed [2*WORD_BITS-1:0] s2_prod_ff;
   logic signed [WIDE-1:0]      s2_simple_ff;
   logic [NUM_BITS-1:0]         s2_num_ff;
   logic [WORD_BITS-1:0]        s2_den_ff;
   logic                        s2_a_neg_ff, s2_b_neg_ff, s2_b_zero_ff;
   logic signed [WIDE-1:0]      simple_in, a_ext, b_ext;
   logic [WORD_BITS-1:0]        a_mag_in, b_mag_in;

   always_comb begin
      a_ext = WIDE'(s1_a_ff);
      b_ext = WIDE'(s1_b_ff);
      a_mag_in = s1_a_ff[WORD_BITS-1] ? WORD_BITS'(-s1_a_ff) : WORD_BITS'(s1_a_ff);
      b_mag_in = s1_b_ff[WORD_BITS-1] ? WORD_BITS'(-s1_b_ff) : WORD_BITS'(s1_b_ff);
      case (s1_action_ff)
         ACT_ADD:   simple_in = a_ext + b_ext;
         ACT_SUB:   simple_in = a_ext - b_ext;
         ACT_FLOOR: simple_in = a_ext & ~WIDE'((64'd1 << FRAC_BITS) - 64'd1);
         ACT_ABS:   simple_in = s1_a_ff[WORD_BITS-1] ? -a_ext : a_ext;
         default:   simple_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_action_ff <= s1_action_ff;
         s2_prod_ff <= s1_a_ff * s1_b_ff;
         s2_simple_ff <= simple_in;
         s2_num_ff <= {a_mag_in, FRAC_BITS'(0)};
         s2_den_ff <= b_mag_in;
         s2_a_neg_ff <= s1_a_ff[WORD_BITS-1];
         s2_b_neg_ff <= s1_b_ff[WORD_BITS-1];
         s2_b_zero_ff <= (s1_b_ff == '0);
      end
   end

   // Stage 3: round the product and pick the non-divide value.
   logic signed [2*WORD_BITS-1:0] rounded_in;
   logic signed [WIDE-1:0]        other_in;

   always_comb begin
      rounded_in = (s2_prod_ff + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      other_in = (s2_action_ff == ACT_MUL) ? WIDE'(rounded_in) : s2_simple_ff;
   end

   logic                div_valid;
   logic [NUM_BITS-1:0] div_quot;
   logic [TAG_BITS-1:0] div_tag;

   q16_div #(
      .NUM_BITS(NUM_BITS),
      .DEN_BITS(WORD_BITS),
      .TAG_BITS(TAG_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (s2_valid_ff),
      .in_num   (s2_num_ff),
      .in_den   (s2_den_ff),
      .in_tag   ({other_in, s2_action_ff, s2_a_neg_ff, s2_b_neg_ff, s2_b_zero_ff}),
      .out_valid(div_valid),
      .out_quot (div_quot),
      .out_tag  (div_tag)
   );

   // Final stage: sign the quotient, flag a zero divisor, saturate, register the response.
   logic signed [WIDE-1:0]      t_other;
   logic [2:0]                  t_action;
   logic                        t_a_neg, t_b_neg, t_b_zero;
   logic signed [WIDE-1:0]      value_in;
   logic signed [WORD_BITS-1:0] result_in;
   logic                        ovf_in, dbz_in;

   always_comb begin
      {t_other, t_action, t_a_neg, t_b_neg, t_b_zero} = div_tag;
      if (t_action == ACT_DIV) begin
         value_in = (t_a_neg ^ t_b_neg) ? -WIDE'(div_quot) : WIDE'(div_quot);
      end else begin
         value_in = t_other;
      end
      dbz_in = 1'b0;
      ovf_in = 1'b0;
      if (t_action == ACT_DIV && t_b_zero) begin
         result_in = NAN_CODE;
         dbz_in = 1'b1;
      end else if (value_in > WIDE'(SAT_MAX)) begin
         result_in = SAT_MAX;
         ovf_in = 1'b1;
      end else if (value_in < -WIDE'(SAT_MAX)) begin
         result_in = -SAT_MAX;
         ovf_in = 1'b1;
      end else begin
         result_in = value_in[WORD_BITS-1:0];
      end
   end

   logic                        out_valid_ff;
   logic signed [WORD_BITS-1:0] out_result_ff;
   logic                        out_ovf_ff, out_dbz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid;
      end
      if (advance) begin
         out_result_ff <= result_in;
         out_ovf_ff <= ovf_in;
         out_dbz_ff <= dbz_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_result_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_divide_by_zero = out_dbz_ff;

endmodule
